[rtl/grb_pkg.sv]
// Shared types and constants of the GPIO register block.
`default_nettype none

package grb_pkg;

	localparam int PIN_COUNT_DEF = 54;
	localparam int PIN_COUNT_MAX = 64;

	// Pins at or above this index have no function select field.
	localparam int FSEL_PIN_LIMIT = 60;
	localparam int FSEL_PER_WORD  = 10;
	localparam int FSEL_WIDTH     = 3;
	localparam int PULL_WIDTH     = 2;
	localparam int DATA_WIDTH     = 32;
	localparam int OFFSET_WIDTH   = 6;

	localparam logic [OFFSET_WIDTH-1:0] OFF_FSEL_LAST = 6'd5;
	localparam logic [OFFSET_WIDTH-1:0] OFF_SET_LO    = 6'd7;
	localparam logic [OFFSET_WIDTH-1:0] OFF_SET_HI    = 6'd8;
	localparam logic [OFFSET_WIDTH-1:0] OFF_CLR_LO    = 6'd10;
	localparam logic [OFFSET_WIDTH-1:0] OFF_CLR_HI    = 6'd11;
	localparam logic [OFFSET_WIDTH-1:0] OFF_LEV_LO    = 6'd13;
	localparam logic [OFFSET_WIDTH-1:0] OFF_LEV_HI    = 6'd14;
	localparam logic [OFFSET_WIDTH-1:0] OFF_PULL_CTRL = 6'd37;
	localparam logic [OFFSET_WIDTH-1:0] OFF_PULL_LO   = 6'd38;
	localparam logic [OFFSET_WIDTH-1:0] OFF_PULL_HI   = 6'd39;

	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	localparam logic [FSEL_WIDTH-1:0] FSEL_INPUT  = 3'd0;
	localparam logic [FSEL_WIDTH-1:0] FSEL_OUTPUT = 3'd1;

	localparam logic [PULL_WIDTH-1:0] PULL_OFF = 2'd0;
	localparam logic [PULL_WIDTH-1:0] PULL_DN  = 2'd1;
	localparam logic [PULL_WIDTH-1:0] PULL_UP  = 2'd2;

	typedef struct packed {
		logic                    func;
		logic [OFFSET_WIDTH-1:0] word_offset;
		logic [DATA_WIDTH-1:0]   write_data;
	} access_t;

endpackage

`default_nettype wire

[rtl/grb_regfile.sv]
// Register file: pin state, write decode, read mux and next pin control vectors.
`default_nettype none

module grb_regfile #(
	parameter int PIN_COUNT = grb_pkg::PIN_COUNT_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            acc_valid,
	input  wire grb_pkg::access_t          acc,
	input  wire  [PIN_COUNT-1:0]           pads,
	output logic [grb_pkg::DATA_WIDTH-1:0] rd_data,
	output logic [PIN_COUNT-1:0]           latch_nxt,
	output logic [PIN_COUNT-1:0]           oe_nxt,
	output logic [PIN_COUNT-1:0]           up_nxt,
	output logic [PIN_COUNT-1:0]           down_nxt
);

	import grb_pkg::*;

	logic [FSEL_WIDTH-1:0] fsel_q [PIN_COUNT];
	logic [FSEL_WIDTH-1:0] fsel_d [PIN_COUNT];
	logic [PULL_WIDTH-1:0] pull_q [PIN_COUNT];
	logic [PULL_WIDTH-1:0] pull_d [PIN_COUNT];
	logic [PIN_COUNT-1:0]  latch_q;
	logic [PULL_WIDTH-1:0] pull_ctrl_q;
	logic [PULL_WIDTH-1:0] pull_ctrl_d;
	logic [PIN_COUNT-1:0]  oe_cur;
	logic [PIN_COUNT-1:0]  level;
	logic [PIN_COUNT_MAX-1:0] level_ext;
	logic [PIN_COUNT_MAX-1:0] data_lo;
	logic [PIN_COUNT_MAX-1:0] data_hi;
	logic [PIN_COUNT_MAX-1:0] pull_sel;
	logic [DATA_WIDTH-1:0] rd_fsel;
	logic                  wr;
	logic                  rd;

	assign wr = acc_valid && (acc.func == FUNC_WRITE);
	assign rd = acc_valid && (acc.func == FUNC_READ);

	assign data_lo = PIN_COUNT_MAX'(acc.write_data);
	assign data_hi = {acc.write_data, {(PIN_COUNT_MAX-DATA_WIDTH){1'b0}}};

	always_comb begin
		for (int p = 0; p < PIN_COUNT; p++) begin
			oe_cur[p] = (fsel_q[p] == FSEL_OUTPUT);
		end
	end

	assign level     = (latch_q & oe_cur) | (pads & ~oe_cur);
	assign level_ext = PIN_COUNT_MAX'(level);

	// function select readback, one 3-bit field per pin in the addressed word
	always_comb begin
		rd_fsel = '0;
		for (int p = 0; p < PIN_COUNT; p++) begin
			if (p < FSEL_PIN_LIMIT && acc.word_offset == OFFSET_WIDTH'(p / FSEL_PER_WORD)) begin
				rd_fsel[FSEL_WIDTH*(p % FSEL_PER_WORD) +: FSEL_WIDTH] = fsel_q[p];
			end
		end
	end

	always_comb begin
		rd_data = '0;
		if (rd) begin
			if (acc.word_offset <= OFF_FSEL_LAST) begin
				rd_data = rd_fsel;
			end else if (acc.word_offset == OFF_LEV_LO) begin
				rd_data = level_ext[DATA_WIDTH-1:0];
			end else if (acc.word_offset == OFF_LEV_HI) begin
				rd_data = level_ext[PIN_COUNT_MAX-1:DATA_WIDTH];
			end else if (acc.word_offset == OFF_PULL_CTRL) begin
				rd_data = DATA_WIDTH'(pull_ctrl_q);
			end
		end
	end

	always_comb begin
		latch_nxt   = latch_q;
		pull_ctrl_d = pull_ctrl_q;
		if (wr) begin
			case (acc.word_offset)
				OFF_SET_LO:    latch_nxt = latch_q | data_lo[PIN_COUNT-1:0];
				OFF_SET_HI:    latch_nxt = latch_q | data_hi[PIN_COUNT-1:0];
				OFF_CLR_LO:    latch_nxt = latch_q & ~data_lo[PIN_COUNT-1:0];
				OFF_CLR_HI:    latch_nxt = latch_q & ~data_hi[PIN_COUNT-1:0];
				OFF_PULL_CTRL: pull_ctrl_d = acc.write_data[PULL_WIDTH-1:0];
				default: begin
					latch_nxt = latch_q;
				end
			endcase
		end
	end

	always_comb begin
		pull_sel = '0;
		if (wr && acc.word_offset == OFF_PULL_LO) begin
			pull_sel = data_lo;
		end else if (wr && acc.word_offset == OFF_PULL_HI) begin
			pull_sel = data_hi;
		end
	end

	always_comb begin
		for (int p = 0; p < PIN_COUNT; p++) begin
			fsel_d[p] = fsel_q[p];
			pull_d[p] = pull_sel[p] ? pull_ctrl_q : pull_q[p];
			if (wr && p < FSEL_PIN_LIMIT && acc.word_offset == OFFSET_WIDTH'(p / FSEL_PER_WORD)) begin
				fsel_d[p] = acc.write_data[FSEL_WIDTH*(p % FSEL_PER_WORD) +: FSEL_WIDTH];
			end
			oe_nxt[p]   = (fsel_d[p] == FSEL_OUTPUT);
			up_nxt[p]   = (pull_d[p] == PULL_UP);
			down_nxt[p] = (pull_d[p] == PULL_DN);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q     <= '0;
			pull_ctrl_q <= PULL_OFF;
			for (int p = 0; p < PIN_COUNT; p++) begin
				fsel_q[p] <= FSEL_INPUT;
				pull_q[p] <= PULL_OFF;
			end
		end else begin
			latch_q     <= latch_nxt;
			pull_ctrl_q <= pull_ctrl_d;
			for (int p = 0; p < PIN_COUNT; p++) begin
				fsel_q[p] <= fsel_d[p];
				pull_q[p] <= pull_d[p];
			end
		end
	end

endmodule

`default_nettype wire

[rtl/gpio_register_block.sv]
// Top level of the GPIO register block: access register, register file, result register.
`default_nettype none

// One register access per transaction, accepted on any cycle where start is high; busy is
// always low, so a new transaction may follow in every cycle. The access is captured in an
// input register and decoded against the pin state the next cycle; its result is on the
// outputs in the cycle after that, with done high for exactly that one cycle. Results cannot
// be stalled. read_data is zero for writes; the pin control outputs show the state after the
// access, and a following transaction sees the updated state.
module gpio_register_block #(
	parameter int PIN_COUNT = grb_pkg::PIN_COUNT_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	output logic                             busy,
	input  wire                              func,
	input  wire  [grb_pkg::OFFSET_WIDTH-1:0] word_offset,
	input  wire  [grb_pkg::DATA_WIDTH-1:0]   write_data,
	input  wire  [PIN_COUNT-1:0]             pad_levels,
	output logic                             done,
	output logic [grb_pkg::DATA_WIDTH-1:0]   read_data,
	output logic [PIN_COUNT-1:0]             drive_levels,
	output logic [PIN_COUNT-1:0]             drive_enables,
	output logic [PIN_COUNT-1:0]             pull_up_enables,
	output logic [PIN_COUNT-1:0]             pull_dn_enables
);

	import grb_pkg::*;

	logic                  valid_s1;
	access_t               acc_s1;
	logic [PIN_COUNT-1:0]  pads_s1;
	logic [DATA_WIDTH-1:0] rd_data;
	logic [PIN_COUNT-1:0]  latch_nxt;
	logic [PIN_COUNT-1:0]  oe_nxt;
	logic [PIN_COUNT-1:0]  up_nxt;
	logic [PIN_COUNT-1:0]  down_nxt;
	logic                  done_s2;
	logic [DATA_WIDTH-1:0] rd_s2;
	logic [PIN_COUNT-1:0]  lev_s2;
	logic [PIN_COUNT-1:0]  oe_s2;
	logic [PIN_COUNT-1:0]  up_s2;
	logic [PIN_COUNT-1:0]  down_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			acc_s1.func        <= func;
			acc_s1.word_offset <= word_offset;
			acc_s1.write_data  <= write_data;
			pads_s1            <= pad_levels;
		end
	end

	grb_regfile #(
		.PIN_COUNT(PIN_COUNT)
	) u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc_valid (valid_s1),
		.acc       (acc_s1),
		.pads      (pads_s1),
		.rd_data   (rd_data),
		.latch_nxt (latch_nxt),
		.oe_nxt    (oe_nxt),
		.up_nxt    (up_nxt),
		.down_nxt  (down_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rd_s2   <= rd_data;
			lev_s2  <= latch_nxt;
			oe_s2   <= oe_nxt;
			up_s2   <= up_nxt;
			down_s2 <= down_nxt;
		end
	end

	assign done            = done_s2;
	assign read_data       = rd_s2;
	assign drive_levels    = lev_s2;
	assign drive_enables   = oe_s2;
	assign pull_up_enables = up_s2;
	assign pull_dn_enables = down_s2;

endmodule

`default_nettype wire

[bench/gpio_register_checker.sv]
// Checker for the GPIO register block: predicts each access and compares its result.
`timescale 1ns / 1ps

module gpio_register_checker #(
	parameter int PIN_COUNT = grb_pkg::PIN_COUNT_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              start,
	input  wire                              busy,
	input  wire                              func,
	input  wire  [grb_pkg::OFFSET_WIDTH-1:0] word_offset,
	input  wire  [grb_pkg::DATA_WIDTH-1:0]   write_data,
	input  wire  [PIN_COUNT-1:0]             pad_levels,
	input  wire                              done,
	input  wire  [grb_pkg::DATA_WIDTH-1:0]   read_data,
	input  wire  [PIN_COUNT-1:0]             drive_levels,
	input  wire  [PIN_COUNT-1:0]             drive_enables,
	input  wire  [PIN_COUNT-1:0]             pull_up_enables,
	input  wire  [PIN_COUNT-1:0]             pull_dn_enables,
	output int                               error_count,
	output int                               pending_count
);
	import grb_pkg::*;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] rdata;
		logic [PIN_COUNT-1:0]  levels;
		logic [PIN_COUNT-1:0]  enables;
		logic [PIN_COUNT-1:0]  ups;
		logic [PIN_COUNT-1:0]  downs;
	} gpio_outcome_t;

	logic [FSEL_WIDTH-1:0] fsel_st [PIN_COUNT];
	logic [PIN_COUNT-1:0]  latch_st;
	logic [PULL_WIDTH-1:0] pull_ctrl_st;
	logic [PULL_WIDTH-1:0] pull_st [PIN_COUNT];

	gpio_outcome_t outcome_q [$];
	int            mismatches;

	function automatic logic [PIN_COUNT-1:0] output_pins();
		logic [PIN_COUNT-1:0] m;
		m = '0;
		for (int p = 0; p < PIN_COUNT; p++)
			if (p < FSEL_PIN_LIMIT && fsel_st[p] == FSEL_OUTPUT)
				m[p] = 1'b1;
		return m;
	endfunction

	task automatic apply_access(input logic wr, input logic [OFFSET_WIDTH-1:0] off,
			input logic [DATA_WIDTH-1:0] data, input logic [PIN_COUNT-1:0] pads,
			output gpio_outcome_t res);
		int                   p;
		logic [PIN_COUNT-1:0] oe;
		logic [PIN_COUNT-1:0] lvl;
		logic [63:0]          wide;
		res = '0;
		if (wr) begin
			if (off <= OFF_FSEL_LAST) begin
				for (int k = 0; k < FSEL_PER_WORD; k++) begin
					p = int'(off) * FSEL_PER_WORD + k;
					if (p < PIN_COUNT && p < FSEL_PIN_LIMIT)
						fsel_st[p] = data[FSEL_WIDTH*k +: FSEL_WIDTH];
				end
			end else begin
				case (off)
					OFF_SET_LO: begin
						wide = {32'b0, data};
						latch_st |= wide[PIN_COUNT-1:0];
					end
					OFF_SET_HI: begin
						wide = {data, 32'b0};
						latch_st |= wide[PIN_COUNT-1:0];
					end
					OFF_CLR_LO: begin
						wide = {32'b0, data};
						latch_st &= ~wide[PIN_COUNT-1:0];
					end
					OFF_CLR_HI: begin
						wide = {data, 32'b0};
						latch_st &= ~wide[PIN_COUNT-1:0];
					end
					OFF_PULL_CTRL: pull_ctrl_st = data[PULL_WIDTH-1:0];
					OFF_PULL_LO, OFF_PULL_HI: begin
						for (int k = 0; k < DATA_WIDTH; k++) begin
							p = (off == OFF_PULL_HI ? 32 : 0) + k;
							if (p < PIN_COUNT && data[k])
								pull_st[p] = pull_ctrl_st;
						end
					end
					default: ;
				endcase
			end
		end else begin
			if (off <= OFF_FSEL_LAST) begin
				for (int k = 0; k < FSEL_PER_WORD; k++) begin
					p = int'(off) * FSEL_PER_WORD + k;
					if (p < PIN_COUNT && p < FSEL_PIN_LIMIT)
						res.rdata[FSEL_WIDTH*k +: FSEL_WIDTH] = fsel_st[p];
				end
			end else if (off == OFF_LEV_LO || off == OFF_LEV_HI) begin
				// driven pins read back their latch, the rest the pad
				oe = output_pins();
				lvl = (latch_st & oe) | (pads & ~oe);
				wide = 64'(lvl);
				res.rdata = (off == OFF_LEV_LO) ? wide[31:0] : wide[63:32];
			end else if (off == OFF_PULL_CTRL) begin
				res.rdata = DATA_WIDTH'(pull_ctrl_st);
			end
		end
		res.levels  = latch_st;
		res.enables = output_pins();
		for (int q = 0; q < PIN_COUNT; q++) begin
			res.ups[q]   = (pull_st[q] == PULL_UP);
			res.downs[q] = (pull_st[q] == PULL_DN);
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		gpio_outcome_t exp_r;
		gpio_outcome_t new_r;
		if (!arst_n) begin
			for (int p = 0; p < PIN_COUNT; p++) begin
				fsel_st[p] = FSEL_INPUT;
				pull_st[p] = PULL_OFF;
			end
			latch_st = '0;
			pull_ctrl_st = PULL_OFF;
			outcome_q.delete();
			mismatches = 0;
			error_count <= 0;
			pending_count <= 0;
		end else begin
			// results first, so a transaction accepted on this edge never matches one
			if (done) begin
				if (outcome_q.size() == 0) begin
					$display("%0t: result with no transaction pending, read_data %h",
						$time, read_data);
					mismatches++;
				end else begin
					exp_r = outcome_q.pop_front();
					check_field("read_data", 64'(exp_r.rdata), 64'(read_data));
					check_field("drive_levels", 64'(exp_r.levels), 64'(drive_levels));
					check_field("drive_enables", 64'(exp_r.enables), 64'(drive_enables));
					check_field("pull_up_enables", 64'(exp_r.ups), 64'(pull_up_enables));
					check_field("pull_dn_enables", 64'(exp_r.downs),
						64'(pull_dn_enables));
				end
			end
			if (start && !busy) begin
				apply_access(func, word_offset, write_data, pad_levels, new_r);
				outcome_q.push_back(new_r);
			end
			error_count <= mismatches;
			pending_count <= outcome_q.size();
		end
	end

endmodule

[bench/tb_gpio_register_block.sv]
// Testbench top of the GPIO register block: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_gpio_register_block;
	import grb_pkg::*;

	localparam int PIN_COUNT    = PIN_COUNT_DEF;
	localparam int ITEM_COUNT   = 2000;
	localparam int QUIET_TAIL   = 200;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 8;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic                    func;
	logic [OFFSET_WIDTH-1:0] word_offset;
	logic [DATA_WIDTH-1:0]   write_data;
	logic [PIN_COUNT-1:0]    pad_levels;
	logic                    done;
	logic [DATA_WIDTH-1:0]   read_data;
	logic [PIN_COUNT-1:0]    drive_levels;
	logic [PIN_COUNT-1:0]    drive_enables;
	logic [PIN_COUNT-1:0]    pull_up_enables;
	logic [PIN_COUNT-1:0]    pull_dn_enables;

	int                   error_count;
	int                   pending_count;
	int                   stall_cycles = 0;
	logic [PIN_COUNT-1:0] pad_state;
	int                   pad_hold;

	gpio_register_block #(.PIN_COUNT(PIN_COUNT)) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.word_offset     (word_offset),
		.write_data      (write_data),
		.pad_levels      (pad_levels),
		.done            (done),
		.read_data       (read_data),
		.drive_levels    (drive_levels),
		.drive_enables   (drive_enables),
		.pull_up_enables (pull_up_enables),
		.pull_dn_enables (pull_dn_enables)
	);

	gpio_register_checker #(.PIN_COUNT(PIN_COUNT)) i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.func            (func),
		.word_offset     (word_offset),
		.write_data      (write_data),
		.pad_levels      (pad_levels),
		.done            (done),
		.read_data       (read_data),
		.drive_levels    (drive_levels),
		.drive_enables   (drive_enables),
		.pull_up_enables (pull_up_enables),
		.pull_dn_enables (pull_dn_enables),
		.error_count     (error_count),
		.pending_count   (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// The pads stay put for two transactions after a level read, so the result does not
	// depend on whether the block samples them at acceptance or at decode.
	task automatic issue(input logic wr, input logic [OFFSET_WIDTH-1:0] off,
			input logic [DATA_WIDTH-1:0] data, input logic [PIN_COUNT-1:0] pads);
		if (pad_hold > 0)
			pad_hold--;
		else
			pad_state = pads;
		start <= 1'b1;
		func <= wr;
		word_offset <= off;
		write_data <= data;
		pad_levels <= pad_state;
		if (wr == FUNC_READ && (off == OFF_LEV_LO || off == OFF_LEV_HI))
			pad_hold = 2;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic pause(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	function automatic logic [PIN_COUNT-1:0] rand_pads();
		logic [63:0] r;
		r = {$urandom, $urandom};
		case ($urandom_range(0, 5))
			0: r = '0;
			1: r = '1;
			default: ;
		endcase
		return r[PIN_COUNT-1:0];
	endfunction

	function automatic logic [DATA_WIDTH-1:0] rand_word();
		logic [DATA_WIDTH-1:0] w;
		case ($urandom_range(0, 7))
			0: w = '0;
			1: w = '1;
			2: w = DATA_WIDTH'(1) << $urandom_range(0, DATA_WIDTH - 1);
			3: w = $urandom & $urandom & $urandom;
			default: w = $urandom;
		endcase
		return w;
	endfunction

	initial begin
		logic                    wr;
		logic [OFFSET_WIDTH-1:0] off;
		logic [DATA_WIDTH-1:0]   data;
		int                      idle_pct;
		int                      pick;
		logic [OFFSET_WIDTH-1:0] latch_offs [4];
		logic [OFFSET_WIDTH-1:0] read_offs [4];

		latch_offs = '{OFF_SET_LO, OFF_SET_HI, OFF_CLR_LO, OFF_CLR_HI};
		read_offs = '{OFF_LEV_LO, OFF_LEV_HI, OFF_PULL_CTRL, OFF_PULL_LO};
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_READ;
		word_offset = '0;
		write_data = '0;
		pad_levels = '0;
		pad_state = '0;
		pad_hold = 0;
		idle_pct = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		issue(FUNC_READ, 6'd0, '0, '0);
		issue(FUNC_READ, OFF_LEV_LO, '0, '1);
		issue(FUNC_WRITE, 6'd0, 32'h0924_9249, '1);         // pins 0..9 to output
		issue(FUNC_WRITE, OFF_FSEL_LAST, '1, '0);           // fields past the last pin
		issue(FUNC_READ, OFF_FSEL_LAST, '0, '0);
		issue(FUNC_WRITE, OFF_SET_LO, '1, '0);
		issue(FUNC_WRITE, OFF_SET_HI, '1, '0);
		issue(FUNC_READ, OFF_LEV_LO, '0, '0);
		issue(FUNC_READ, OFF_LEV_HI, '0, '0);
		issue(FUNC_WRITE, OFF_CLR_LO, 32'h0000_00AA, '1);
		issue(FUNC_WRITE, OFF_CLR_HI, '1, '1);
		issue(FUNC_READ, OFF_LEV_LO, '0, '1);
		issue(FUNC_WRITE, OFF_PULL_CTRL, 32'hFFFF_FFFE, '0); // pull up, upper bits set
		issue(FUNC_READ, OFF_PULL_CTRL, '0, '0);
		issue(FUNC_WRITE, OFF_PULL_LO, '1, '0);
		issue(FUNC_WRITE, OFF_PULL_CTRL, 32'd1, '0);
		issue(FUNC_WRITE, OFF_PULL_HI, '1, '0);
		issue(FUNC_WRITE, OFF_PULL_CTRL, 32'd3, '0);        // code three: no pull
		issue(FUNC_WRITE, OFF_PULL_LO, 32'h0000_000F, '0);
		issue(FUNC_READ, OFF_PULL_LO, '0, '0);
		issue(FUNC_WRITE, 6'd63, '1, '1);                   // unmapped offset
		issue(FUNC_READ, 6'd63, '0, '1);
		issue(FUNC_WRITE, OFF_LEV_LO, '1, '0);              // level word ignores writes
		issue(FUNC_READ, OFF_SET_LO, '0, '0);
		issue(FUNC_WRITE, 6'd1, 32'hD234_5678, '0);         // alternate function codes
		issue(FUNC_READ, 6'd1, '0, '0);

		// random part: mostly meaningful accesses, some noise
		for (int i = 0; i < ITEM_COUNT; i++) begin
			if (i % 128 == 0)
				idle_pct = $urandom_range(0, 3) * 10;
			if (i < ITEM_COUNT - QUIET_TAIL && $urandom_range(1, 100) <= idle_pct)
				pause($urandom_range(1, 15));
			pick = $urandom_range(0, 99);
			wr = FUNC_WRITE;
			data = rand_word();
			if (pick < 25) begin
				off = OFFSET_WIDTH'($urandom_range(0, 5));
				for (int k = 0; k < FSEL_PER_WORD; k++) begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3: data[FSEL_WIDTH*k +: FSEL_WIDTH] = FSEL_OUTPUT;
						4, 5, 6: data[FSEL_WIDTH*k +: FSEL_WIDTH] = FSEL_INPUT;
						default: data[FSEL_WIDTH*k +: FSEL_WIDTH] = FSEL_WIDTH'($urandom);
					endcase
				end
				data[31:30] = 2'($urandom);
			end else if (pick < 42) begin
				off = latch_offs[$urandom_range(0, 3)];
			end else if (pick < 50) begin
				off = OFF_PULL_CTRL;
			end else if (pick < 60) begin
				off = $urandom_range(0, 1) ? OFF_PULL_HI : OFF_PULL_LO;
			end else if (pick < 85) begin
				wr = FUNC_READ;
				case ($urandom_range(0, 5))
					0, 1: off = OFFSET_WIDTH'($urandom_range(0, 5));
					2: off = OFFSET_WIDTH'($urandom);
					default: off = read_offs[$urandom_range(0, 3)];
				endcase
				if ($urandom_range(0, 1))
					data = '0;
			end else begin
				wr = 1'($urandom);
				off = OFFSET_WIDTH'($urandom);
			end
			issue(wr, off, data, rand_pads());
		end
		start <= 1'b0;
		@(posedge clk);

		while (pending_count != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[files.f]
rtl/grb_pkg.sv
rtl/grb_regfile.sv
rtl/gpio_register_block.sv
bench/gpio_register_checker.sv
bench/tb_gpio_register_block.sv
